### rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants shared by the shell word splitter modules.
// ----------------------------------------------------------------------------
package sws_pkg;

  // Splitter state
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_ARG     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_DQ      = 3'd3,
    MODE_DQ_ESC  = 3'd4,
    MODE_SQ      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_OPEN_DQ = 2'd2,
    STATUS_OPEN_SQ = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic [7:0] REG_SEP_A = 8'd0;
  localparam logic [7:0] REG_SEP_B = 8'd1;
  localparam logic [7:0] REG_SEP_C = 8'd2;
  localparam logic [7:0] REG_SEP_D = 8'd3;

  localparam logic [7:0] SEP_A_RESET = 8'd32;
  localparam logic [7:0] SEP_B_RESET = 8'd9;
  localparam logic [7:0] SEP_C_RESET = 8'd10;
  localparam logic [7:0] SEP_D_RESET = 8'd0;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;

  localparam int ArgWidth = 12;
  localparam int LenWidth = 13;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  // One entry of the queue: the one or two words caused by a single input
  typedef struct packed {
    logic                two;
    kind_e               kind0;
    logic [7:0]          data0;
    kind_e               kind1;
    logic [7:0]          data1;
    logic [ArgWidth-1:0] arg_total;
    logic [LenWidth-1:0] stored_length;
    status_e             status;
    logic [LenWidth-1:0] error_column;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

### rtl/sws_if.sv
// ----------------------------------------------------------------------------
// sws_if
// Handshake channels of the shell word splitter: input, result and config.
// ----------------------------------------------------------------------------
interface sws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source (output valid, in_byte, line_end, input ready);
  modport sink   (input valid, in_byte, line_end, output ready);
endinterface

interface sws_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [11:0] arg_total;
  logic [12:0] stored_length;
  logic [1:0]  status;
  logic [12:0] error_column;
  logic        last;

  modport source (output valid, kind, data_byte, arg_total, stored_length, status,
                  error_column, last, input ready);
  modport sink   (input valid, kind, data_byte, arg_total, stored_length, status,
                  error_column, last, output ready);
endinterface

interface sws_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sws_front.sv
// ----------------------------------------------------------------------------
// sws_front
// Accepts bytes, runs the quoting state machine and the line counters, and
// packs the words each byte causes into one queue entry.
// ----------------------------------------------------------------------------
module sws_front #(
  parameter int MAX_LINE = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sws_in_if.sink            in_i,
  sws_cfg_if.sink           cfg_i,
  input  logic              space_i,
  output logic              push_o,
  output sws_pkg::cmd_t     cmd_o
);

  localparam int LenCap = (MAX_LINE < 8191) ? MAX_LINE : 8191;
  localparam int ArgCap = ((MAX_LINE / 2) < 4095) ? (MAX_LINE / 2) : 4095;
  localparam logic [sws_pkg::LenWidth-1:0] LenCapV = sws_pkg::LenWidth'(LenCap);
  localparam logic [sws_pkg::ArgWidth-1:0] ArgCapV = sws_pkg::ArgWidth'(ArgCap);

  logic [7:0] sep_a_q, sep_b_q, sep_c_q, sep_d_q;

  sws_pkg::mode_e                  mode_q, mode_d;
  logic [sws_pkg::LenWidth-1:0]    column_q, column_d;
  logic [sws_pkg::LenWidth-1:0]    qcol_q, qcol_d;
  logic [sws_pkg::ArgWidth-1:0]    argc_q, argc_d;
  logic [sws_pkg::LenWidth-1:0]    bcnt_q, bcnt_d;

  logic                            in_fire, cfg_fire;
  logic [7:0]                      b;
  logic                            is_sep;
  logic [sws_pkg::LenWidth-1:0]    col_inc, bc_one, bc_two, bc_new;
  logic [1:0]                      nres, nbytes;
  sws_pkg::kind_e                  k0, k1;
  logic [7:0]                      d0, d1;
  sws_pkg::status_e                status;
  logic [sws_pkg::LenWidth-1:0]    ecol;

  assign in_i.ready  = space_i;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_a_q <= sws_pkg::SEP_A_RESET;
      sep_b_q <= sws_pkg::SEP_B_RESET;
      sep_c_q <= sws_pkg::SEP_C_RESET;
      sep_d_q <= sws_pkg::SEP_D_RESET;
    end else if (cfg_fire) begin
      priority case (cfg_i.index)
        sws_pkg::REG_SEP_A: sep_a_q <= cfg_i.data;
        sws_pkg::REG_SEP_B: sep_b_q <= cfg_i.data;
        sws_pkg::REG_SEP_C: sep_c_q <= cfg_i.data;
        sws_pkg::REG_SEP_D: sep_d_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign b      = in_i.in_byte;
  assign is_sep = (b == sws_pkg::CH_NUL) || (b == sep_a_q) || (b == sep_b_q) ||
                  (b == sep_c_q) || (b == sep_d_q);

  assign col_inc = (column_q < LenCapV) ? column_q + 1'b1 : column_q;
  assign bc_one  = (bcnt_q < LenCapV) ? bcnt_q + 1'b1 : bcnt_q;
  assign bc_two  = (bc_one < LenCapV) ? bc_one + 1'b1 : bc_one;

  always_comb begin
    mode_d   = mode_q;
    column_d = column_q;
    qcol_d   = qcol_q;
    argc_d   = argc_q;
    nres     = 2'd0;
    nbytes   = 2'd0;
    k0       = sws_pkg::KIND_DATA;
    k1       = sws_pkg::KIND_DATA;
    d0       = 8'd0;
    d1       = 8'd0;
    status   = sws_pkg::STATUS_OK;
    ecol     = '0;

    if (in_i.line_end) begin
      unique case (mode_q)
        sws_pkg::MODE_ARG, sws_pkg::MODE_ESC: begin
          // close the open argument before the summary
          nres   = 2'd2;
          nbytes = 2'd1;
          k0     = sws_pkg::KIND_END;
          k1     = sws_pkg::KIND_SUMMARY;
        end
        sws_pkg::MODE_DQ, sws_pkg::MODE_DQ_ESC: begin
          nres   = 2'd1;
          k0     = sws_pkg::KIND_SUMMARY;
          status = sws_pkg::STATUS_OPEN_DQ;
          ecol   = qcol_q;
        end
        sws_pkg::MODE_SQ: begin
          nres   = 2'd1;
          k0     = sws_pkg::KIND_SUMMARY;
          status = sws_pkg::STATUS_OPEN_SQ;
          ecol   = qcol_q;
        end
        default: begin
          nres = 2'd1;
          k0   = sws_pkg::KIND_SUMMARY;
          if (column_q == '0) status = sws_pkg::STATUS_EMPTY;
        end
      endcase
    end else begin
      column_d = col_inc;
      unique case (mode_q)
        sws_pkg::MODE_ESC: begin
          mode_d = sws_pkg::MODE_ARG;
          if (b == sws_pkg::CH_DQ || b == sws_pkg::CH_SQ || is_sep) begin
            nres   = 2'd1;
            nbytes = 2'd1;
            d0     = b;
          end else begin
            nres   = 2'd2;
            nbytes = 2'd2;
            d0     = sws_pkg::CH_BS;
            d1     = b;
          end
        end
        sws_pkg::MODE_DQ: begin
          if (b == sws_pkg::CH_DQ) begin
            mode_d = sws_pkg::MODE_ARG;
          end else if (b == sws_pkg::CH_BS) begin
            mode_d = sws_pkg::MODE_DQ_ESC;
          end else begin
            nres   = 2'd1;
            nbytes = 2'd1;
            d0     = b;
          end
        end
        sws_pkg::MODE_DQ_ESC: begin
          mode_d = sws_pkg::MODE_DQ;
          if (b == sws_pkg::CH_DQ) begin
            nres   = 2'd1;
            nbytes = 2'd1;
            d0     = b;
          end else begin
            nres   = 2'd2;
            nbytes = 2'd2;
            d0     = sws_pkg::CH_BS;
            d1     = b;
          end
        end
        sws_pkg::MODE_SQ: begin
          if (b == sws_pkg::CH_SQ) begin
            mode_d = sws_pkg::MODE_ARG;
          end else begin
            nres   = 2'd1;
            nbytes = 2'd1;
            d0     = b;
          end
        end
        default: begin
          if (is_sep) begin
            if (mode_q == sws_pkg::MODE_ARG) begin
              nres   = 2'd1;
              nbytes = 2'd1;
              k0     = sws_pkg::KIND_END;
            end
            mode_d = sws_pkg::MODE_BETWEEN;
          end else begin
            if (mode_q != sws_pkg::MODE_ARG && argc_q < ArgCapV) argc_d = argc_q + 1'b1;
            priority if (b == sws_pkg::CH_BS) begin
              mode_d = sws_pkg::MODE_ESC;
            end else if (b == sws_pkg::CH_DQ) begin
              qcol_d = col_inc;
              mode_d = sws_pkg::MODE_DQ;
            end else if (b == sws_pkg::CH_SQ) begin
              qcol_d = col_inc;
              mode_d = sws_pkg::MODE_SQ;
            end else begin
              nres   = 2'd1;
              nbytes = 2'd1;
              d0     = b;
              mode_d = sws_pkg::MODE_ARG;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (nbytes)
      2'd0:    bc_new = bcnt_q;
      2'd1:    bc_new = bc_one;
      default: bc_new = bc_two;
    endcase
  end

  // on a line end everything but the separators returns to reset
  assign bcnt_d = in_i.line_end ? '0 : bc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sws_pkg::MODE_BETWEEN;
      column_q <= '0;
      qcol_q   <= '0;
      argc_q   <= '0;
      bcnt_q   <= '0;
    end else if (in_fire) begin
      if (in_i.line_end) begin
        mode_q   <= sws_pkg::MODE_BETWEEN;
        column_q <= '0;
        qcol_q   <= '0;
        argc_q   <= '0;
      end else begin
        mode_q   <= mode_d;
        column_q <= column_d;
        qcol_q   <= qcol_d;
        argc_q   <= argc_d;
      end
      bcnt_q <= bcnt_d;
    end
  end

  assign push_o              = in_fire && (nres != 2'd0);
  assign cmd_o.two           = (nres == 2'd2);
  assign cmd_o.kind0         = k0;
  assign cmd_o.data0         = d0;
  assign cmd_o.kind1         = k1;
  assign cmd_o.data1         = d1;
  assign cmd_o.arg_total     = argc_q;
  assign cmd_o.stored_length = bc_new;
  assign cmd_o.status        = status;
  assign cmd_o.error_column  = ecol;

`ifndef SYNTHESIS
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.line_end |=> mode_q == sws_pkg::MODE_BETWEEN && column_q == '0 &&
                                 bcnt_q == '0 && argc_q == '0)
    else $error("line state not cleared after line end");

  a_counts_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= LenCapV && column_q <= LenCapV && argc_q <= ArgCapV)
    else $error("line counter beyond its cap");

  a_sq_copies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.line_end && mode_q == sws_pkg::MODE_SQ && in_i.in_byte != sws_pkg::CH_SQ
    |-> push_o && cmd_o.kind0 == sws_pkg::KIND_DATA && cmd_o.data0 == in_i.in_byte)
    else $error("byte inside single quotes not copied");
`endif

endmodule

### rtl/sws_queue.sv
// ----------------------------------------------------------------------------
// sws_queue
// Short queue of packed word groups between the front and the back end.
// ----------------------------------------------------------------------------
module sws_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sws_pkg::cmd_t   cmd_i,
  output logic            space_o,
  input  logic            pop_i,
  output sws_pkg::head_t  head_o
);

  sws_pkg::cmd_t                 mem_q [sws_pkg::QueueDepth];
  logic [sws_pkg::QueueAw-1:0]   wptr_q, rptr_q;
  logic [sws_pkg::QueueCw-1:0]   count_q, count_d;
  logic                          do_pop;

  assign space_o      = (count_q != sws_pkg::QueueCw'(sws_pkg::QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) count_d = count_q + 1'b1;
    if (!push_i && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sws_pkg::QueueCw'(sws_pkg::QueueDepth))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != sws_pkg::QueueCw'(sws_pkg::QueueDepth)
    |-> sws_pkg::QueueAw'(wptr_q - rptr_q) == sws_pkg::QueueAw'(count_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/sws_back.sv
// ----------------------------------------------------------------------------
// sws_back
// Unpacks each queue entry into one or two result words on the output port.
// ----------------------------------------------------------------------------
module sws_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sws_pkg::head_t  head_i,
  output logic            pop_o,
  sws_out_if.source       out_o
);

  logic            sel_q, sel_d;
  logic            out_fire, last;
  sws_pkg::kind_e  kind;
  logic            is_sum;

  assign kind     = sel_q ? head_i.cmd.kind1 : head_i.cmd.kind0;
  assign last     = !head_i.cmd.two || sel_q;
  assign is_sum   = (kind == sws_pkg::KIND_SUMMARY);
  assign out_fire = out_o.valid && out_o.ready;
  assign pop_o    = out_fire && last;

  // step to the second word, back to the first once the entry is gone
  assign sel_d = out_fire ? !last : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_q <= 1'b0;
    else         sel_q <= sel_d;
  end

  assign out_o.valid         = head_i.valid;
  assign out_o.kind          = kind;
  assign out_o.data_byte     = sel_q ? head_i.cmd.data1 : head_i.cmd.data0;
  assign out_o.arg_total     = is_sum ? head_i.cmd.arg_total : '0;
  assign out_o.stored_length = is_sum ? head_i.cmd.stored_length : '0;
  assign out_o.status        = is_sum ? head_i.cmd.status : sws_pkg::STATUS_OK;
  assign out_o.error_column  = is_sum ? head_i.cmd.error_column : '0;
  assign out_o.last          = last;

`ifndef SYNTHESIS
  a_sel_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> head_i.valid && head_i.cmd.two)
    else $error("second word selected without a pair entry");

  a_sel_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !sel_q)
    else $error("word select not returned after pop");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid && is_sum |-> last)
    else $error("summary not the final word of its entry");
`endif

endmodule

### rtl/shell_word_splitter.sv
// ----------------------------------------------------------------------------
// shell_word_splitter
// Shell-style argument splitter: bytes in, argument bytes, argument ends and
// a line summary out.
// ----------------------------------------------------------------------------
// One byte or line end is taken per cycle while the four-entry queue between
// front and back end has room. Each input gives zero, one or two result
// words; the back end drives one word per cycle from the queue head while
// the output is ready, so an input giving two words (backslash pairs, final
// argument end plus summary) holds the output port for both of them and the
// output port sets the sustained rate. An input's words are registered in
// the queue before they are output. Separator registers may be written at
// any time the block is idle; the config port never stalls.
// ----------------------------------------------------------------------------
module shell_word_splitter #(
  parameter int MAX_LINE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sws_in_if.sink      in_i,
  sws_out_if.source   out_o,
  sws_cfg_if.sink     cfg_i
);

  logic            push, space, pop;
  sws_pkg::cmd_t   cmd;
  sws_pkg::head_t  head;

  sws_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .space_i (space),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  sws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .space_o (space),
    .pop_i   (pop),
    .head_o  (head)
  );

  sws_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
